[design/sfwc_pkg.sv]
// shared types, constants and phase enum for the sector write-back cache
// no dependencies
`timescale 1ns / 1ps
package sfwc_pkg;

   localparam int SECTOR_BYTES = 4096;
   localparam int BLOCK_BYTES = 512;
   localparam int PAGE_BYTES = 256;
   localparam int SECTOR_COUNT = 2048;
   localparam int SECTOR_BLOCKS = SECTOR_BYTES / BLOCK_BYTES;
   localparam int SECTOR_PAGES = SECTOR_BYTES / PAGE_BYTES;
   localparam int IDX_W = $clog2(SECTOR_BYTES);
   localparam int SEC_W = $clog2(SECTOR_COUNT);
   localparam int PG_W = $clog2(SECTOR_PAGES);
   localparam int BPS_W = $clog2(SECTOR_BLOCKS);
   localparam int OFF_W = $clog2(BLOCK_BYTES);
   localparam int PGB_W = $clog2(PAGE_BYTES);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   localparam logic [7:0] OP_WREN = 8'h06;
   localparam logic [7:0] OP_PROG = 8'h02;
   localparam logic [7:0] OP_READ = 8'h03;
   localparam logic [7:0] OP_RDSR = 8'h05;
   localparam logic [7:0] OP_ERASE = 8'h20;
   localparam logic [7:0] BYTE_IDLE = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WE_CMD, PH_WE_END, PH_OP_CMD, PH_OP_ADDR, PH_PROG_DATA,
      PH_WAIT_END, PH_POLL_CMD, PH_POLL_FIRST, PH_POLL_CHECK, PH_FINAL,
      PH_LD_CMD, PH_LD_ADDR, PH_LD_READ, PH_LD_END
   } phase_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [13:0] host_block;
      logic [8:0] byte_offset;
      logic [7:0] write_data;
      logic [7:0] miso_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] host_status;
      logic [7:0] read_data;
      logic spi_active;
      logic chip_select_n;
      logic [7:0] mosi_byte;
      logic sequence_idle;
   } rsp_type;

   typedef enum logic [2:0] {
      MS_NONE, MS_OPCODE, MS_WB_ADDR, MS_LD_ADDR, MS_STORE, MS_IDLE_FF
   } mosi_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic host_write;
      logic mem_read_host;
      logic mem_read_prog;
      logic mem_write_load;
      logic [IDX_W-1:0] load_idx;
      logic [PG_W-1:0] page;
      logic [1:0] addr_k;
      logic erase;
      logic set_target;
      mosi_sel_type mosi_sel;
      logic [7:0] opcode;
      logic cs_n;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic hit;
      logic [SEC_W-1:0] req_sector;
   } sts_type;

endpackage

[design/sfwc_datapath.sv]
// sector store, address arithmetic and result byte selection
// depends on sfwc_pkg
`timescale 1ns / 1ps
module sfwc_datapath (
   input logic clock,
   input sfwc_pkg::req_type req,
   input sfwc_pkg::ctl_type ctl,
   input logic valid_q,
   input logic [sfwc_pkg::SEC_W-1:0] current_sector,
   output sfwc_pkg::sts_type sts,
   output logic [7:0] mem_q,
   output logic [7:0] mosi_q
);

   logic [7:0] store_mem [sfwc_pkg::SECTOR_BYTES];
   logic [sfwc_pkg::SEC_W-1:0] target_ff;
   logic [7:0] rd_ff;
   logic [7:0] mosi_ff;
   logic store_sel_ff;
   logic [sfwc_pkg::SEC_W-1:0] req_sector;
   logic [sfwc_pkg::IDX_W-1:0] host_idx;
   logic [sfwc_pkg::IDX_W-1:0] rd_idx;
   logic [23:0] addr;
   logic [7:0] addr_byte;
   logic [sfwc_pkg::SEC_W-1:0] addr_sector;
   logic [7:0] mosi_in;

   assign req_sector = sfwc_pkg::SEC_W'(req.host_block >> sfwc_pkg::BPS_W);
   assign host_idx = sfwc_pkg::IDX_W'({req.host_block[sfwc_pkg::BPS_W-1:0],
                                       req.byte_offset[sfwc_pkg::OFF_W-1:0]});
   assign sts.hit = valid_q && (current_sector == req_sector);
   assign sts.req_sector = req_sector;

   always_comb begin
      addr_sector = (ctl.mosi_sel == sfwc_pkg::MS_LD_ADDR) ? target_ff : current_sector;
      addr = 24'(addr_sector) << sfwc_pkg::IDX_W;
      if (ctl.mosi_sel == sfwc_pkg::MS_WB_ADDR && !ctl.erase)
         addr = addr | (24'(ctl.page) << sfwc_pkg::PGB_W);
      case (ctl.addr_k)
         2'd0: addr_byte = addr[23:16];
         2'd1: addr_byte = addr[15:8];
         default: addr_byte = addr[7:0];
      endcase
      case (ctl.mosi_sel)
         sfwc_pkg::MS_OPCODE: mosi_in = ctl.opcode;
         sfwc_pkg::MS_WB_ADDR, sfwc_pkg::MS_LD_ADDR: mosi_in = addr_byte;
         sfwc_pkg::MS_IDLE_FF: mosi_in = sfwc_pkg::BYTE_IDLE;
         default: mosi_in = sfwc_pkg::BYTE_ZERO;
      endcase
      rd_idx = ctl.mem_read_prog ? ctl.load_idx : host_idx;
   end

   always_ff @(posedge clock) begin
      if (ctl.set_target)
         target_ff <= req_sector;
      if (ctl.host_write)
         store_mem[host_idx] <= req.write_data;
      else if (ctl.mem_write_load)
         store_mem[ctl.load_idx] <= req.miso_byte;
      if (ctl.mem_read_host || ctl.mem_read_prog)
         rd_ff <= store_mem[rd_idx];
      mosi_ff <= mosi_in;
      store_sel_ff <= (ctl.mosi_sel == sfwc_pkg::MS_STORE);
   end

   assign mem_q = rd_ff;
   // page program bytes come straight from the store read
   assign mosi_q = store_sel_ff ? rd_ff : mosi_ff;

endmodule

[design/sfwc_controller.sv]
// sequence state machine: phases, counters, cache flags and result control
// depends on sfwc_pkg
`timescale 1ns / 1ps
module sfwc_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sfwc_pkg::req_type req,
   input logic rsp_ready,
   output logic rsp_valid,
   output sfwc_pkg::rsp_type rsp,
   output sfwc_pkg::ctl_type ctl,
   input sfwc_pkg::sts_type sts,
   output logic valid_q,
   output logic [sfwc_pkg::SEC_W-1:0] current_sector,
   input logic [7:0] mem_q,
   input logic [7:0] mosi_q
);

   sfwc_pkg::phase_type phase_ff, phase_in;
   logic [sfwc_pkg::IDX_W:0] cnt_ff, cnt_in;
   logic [sfwc_pkg::PG_W-1:0] page_ff, page_in;
   logic valid_ff, valid_in, dirty_ff, dirty_in, erase_ff, erase_in;
   logic lf_ff, lf_in;
   logic [sfwc_pkg::SEC_W-1:0] cur_ff, cur_in;
   // sector latched at a miss, taken over when the load completes
   logic [sfwc_pkg::SEC_W-1:0] tgt_ff;
   // result holding stage: memory read data and mosi byte arrive in the cycle after accept
   logic out_ff, out_in;
   logic [1:0] st_ff, st_in;
   logic rdsel_ff, rdsel_in;
   logic act_ff, act_in, cs_ff, cs_in, idle_ff, idle_in;
   logic [7:0] rdata_ff;
   logic [7:0] mosi_hold_ff;
   logic fresh_ff;
   logic accept;
   logic tgt_ld;

   assign valid_q = valid_ff;
   assign current_sector = cur_ff;
   assign req_ready = !out_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = out_ff;

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      page_in = page_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      erase_in = erase_ff;
      lf_in = lf_ff;
      cur_in = cur_ff;
      out_in = out_ff && !rsp_ready;
      st_in = st_ff;
      rdsel_in = rdsel_ff;
      act_in = act_ff;
      cs_in = cs_ff;
      idle_in = idle_ff;
      tgt_ld = 1'b0;
      ctl = '0;
      ctl.mosi_sel = sfwc_pkg::MS_NONE;
      ctl.page = page_ff;
      ctl.erase = erase_ff;
      ctl.cs_n = 1'b1;
      ctl.load_idx = sfwc_pkg::IDX_W'(cnt_ff);
      if (accept) begin
         out_in = 1'b1;
         st_in = sfwc_pkg::ST_DONE;
         rdsel_in = 1'b0;
         act_in = 1'b0;
         cs_in = 1'b1;
         if (req.cmd == sfwc_pkg::CMD_TICK) begin
            if (phase_ff != sfwc_pkg::PH_IDLE) begin
               act_in = 1'b1;
               case (phase_ff)
                  sfwc_pkg::PH_WE_CMD: begin
                     ctl.mosi_sel = sfwc_pkg::MS_OPCODE; ctl.opcode = sfwc_pkg::OP_WREN;
                     ctl.cs_n = 1'b0;
                     phase_in = sfwc_pkg::PH_WE_END; cnt_in = '0;
                  end
                  sfwc_pkg::PH_WE_END: begin
                     ctl.mosi_sel = sfwc_pkg::MS_IDLE_FF;
                     if (cnt_ff == 1) begin
                        phase_in = sfwc_pkg::PH_OP_CMD; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_OP_CMD: begin
                     ctl.mosi_sel = sfwc_pkg::MS_OPCODE; ctl.cs_n = 1'b0;
                     ctl.opcode = erase_ff ? sfwc_pkg::OP_ERASE : sfwc_pkg::OP_PROG;
                     phase_in = sfwc_pkg::PH_OP_ADDR; cnt_in = '0;
                  end
                  sfwc_pkg::PH_OP_ADDR: begin
                     ctl.mosi_sel = sfwc_pkg::MS_WB_ADDR; ctl.cs_n = 1'b0;
                     ctl.addr_k = cnt_ff[1:0];
                     if (cnt_ff == 2) begin
                        phase_in = erase_ff ? sfwc_pkg::PH_WAIT_END : sfwc_pkg::PH_PROG_DATA;
                        cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_PROG_DATA: begin
                     ctl.mosi_sel = sfwc_pkg::MS_STORE; ctl.cs_n = 1'b0;
                     ctl.mem_read_prog = 1'b1;
                     ctl.load_idx = sfwc_pkg::IDX_W'({page_ff,
                        cnt_ff[sfwc_pkg::PGB_W-1:0]});
                     if (cnt_ff == (sfwc_pkg::PAGE_BYTES - 1)) begin
                        phase_in = sfwc_pkg::PH_WAIT_END; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_WAIT_END: begin
                     ctl.mosi_sel = sfwc_pkg::MS_IDLE_FF;
                     if (cnt_ff == 1) begin
                        phase_in = sfwc_pkg::PH_POLL_CMD; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_POLL_CMD: begin
                     ctl.mosi_sel = sfwc_pkg::MS_OPCODE; ctl.opcode = sfwc_pkg::OP_RDSR;
                     ctl.cs_n = 1'b0; phase_in = sfwc_pkg::PH_POLL_FIRST;
                  end
                  sfwc_pkg::PH_POLL_FIRST: begin
                     ctl.mosi_sel = sfwc_pkg::MS_NONE; ctl.cs_n = 1'b0;
                     phase_in = sfwc_pkg::PH_POLL_CHECK;
                  end
                  sfwc_pkg::PH_POLL_CHECK: begin
                     if (req.miso_byte[0]) begin
                        ctl.mosi_sel = sfwc_pkg::MS_NONE; ctl.cs_n = 1'b0;
                     end else begin
                        ctl.mosi_sel = sfwc_pkg::MS_IDLE_FF;
                        phase_in = sfwc_pkg::PH_FINAL;
                        cnt_in = (sfwc_pkg::IDX_W + 1)'(1);
                     end
                  end
                  sfwc_pkg::PH_FINAL: begin
                     ctl.mosi_sel = sfwc_pkg::MS_IDLE_FF;
                     if (cnt_ff == 3) begin
                        cnt_in = '0;
                        if (erase_ff) begin
                           erase_in = 1'b0; page_in = '0; phase_in = sfwc_pkg::PH_WE_CMD;
                        end else if (page_ff != sfwc_pkg::PG_W'(sfwc_pkg::SECTOR_PAGES - 1))
                        begin
                           page_in = page_ff + 1'b1; phase_in = sfwc_pkg::PH_WE_CMD;
                        end else begin
                           dirty_in = 1'b0;
                           if (lf_ff) begin
                              lf_in = 1'b0; valid_in = 1'b0;
                              phase_in = sfwc_pkg::PH_LD_CMD;
                           end else
                              phase_in = sfwc_pkg::PH_IDLE;
                        end
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_LD_CMD: begin
                     ctl.mosi_sel = sfwc_pkg::MS_OPCODE; ctl.opcode = sfwc_pkg::OP_READ;
                     ctl.cs_n = 1'b0; phase_in = sfwc_pkg::PH_LD_ADDR; cnt_in = '0;
                  end
                  sfwc_pkg::PH_LD_ADDR: begin
                     ctl.mosi_sel = sfwc_pkg::MS_LD_ADDR; ctl.cs_n = 1'b0;
                     ctl.addr_k = cnt_ff[1:0];
                     if (cnt_ff == 2) begin
                        phase_in = sfwc_pkg::PH_LD_READ; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_LD_READ: begin
                     ctl.mosi_sel = sfwc_pkg::MS_NONE; ctl.cs_n = 1'b0;
                     // byte from the previous transfer lands one slot back
                     ctl.mem_write_load = (cnt_ff != 0);
                     ctl.load_idx = sfwc_pkg::IDX_W'(cnt_ff - 1'b1);
                     if (cnt_ff == (sfwc_pkg::SECTOR_BYTES - 1)) begin
                        phase_in = sfwc_pkg::PH_LD_END; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  sfwc_pkg::PH_LD_END: begin
                     ctl.mosi_sel = sfwc_pkg::MS_IDLE_FF;
                     ctl.mem_write_load = (cnt_ff == 0);
                     ctl.load_idx = sfwc_pkg::IDX_W'(sfwc_pkg::SECTOR_BYTES - 1);
                     if (cnt_ff == 1) begin
                        valid_in = 1'b1; cur_in = tgt_ff; dirty_in = 1'b0;
                        phase_in = sfwc_pkg::PH_IDLE; cnt_in = '0;
                     end else
                        cnt_in = cnt_ff + 1'b1;
                  end
                  default: begin
                     act_in = 1'b0; phase_in = sfwc_pkg::PH_IDLE;
                  end
               endcase
               cs_in = ctl.cs_n;
            end
         end else if (phase_ff != sfwc_pkg::PH_IDLE) begin
            st_in = sfwc_pkg::ST_BUSY;
         end else if (req.cmd == sfwc_pkg::CMD_FLUSH) begin
            if (valid_ff && dirty_ff) begin
               lf_in = 1'b0; erase_in = 1'b1; page_in = '0; cnt_in = '0;
               phase_in = sfwc_pkg::PH_WE_CMD; st_in = sfwc_pkg::ST_MISS;
            end
         end else if (sts.hit) begin
            if (req.cmd == sfwc_pkg::CMD_WRITE) begin
               ctl.host_write = 1'b1; dirty_in = 1'b1;
            end else begin
               ctl.mem_read_host = 1'b1; rdsel_in = 1'b1;
            end
         end else begin
            tgt_ld = 1'b1; ctl.set_target = 1'b1; st_in = sfwc_pkg::ST_MISS;
            if (valid_ff && dirty_ff) begin
               lf_in = 1'b1; erase_in = 1'b1; page_in = '0; cnt_in = '0;
               phase_in = sfwc_pkg::PH_WE_CMD;
            end else begin
               valid_in = 1'b0; phase_in = sfwc_pkg::PH_LD_CMD; cnt_in = '0;
            end
         end
         idle_in = (phase_in == sfwc_pkg::PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfwc_pkg::PH_IDLE;
         cnt_ff <= '0;
         page_ff <= '0;
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         erase_ff <= 1'b0;
         lf_ff <= 1'b0;
         cur_ff <= '0;
         tgt_ff <= '0;
         out_ff <= 1'b0;
         fresh_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         page_ff <= page_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         erase_ff <= erase_in;
         lf_ff <= lf_in;
         cur_ff <= cur_in;
         if (tgt_ld)
            tgt_ff <= sts.req_sector;
         out_ff <= out_in;
         fresh_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      rdsel_ff <= rdsel_in;
      act_ff <= act_in;
      cs_ff <= cs_in;
      idle_ff <= idle_in;
      // capture memory and mosi bytes in the cycle after accept, hold after
      if (fresh_ff) begin
         rdata_ff <= mem_q;
         mosi_hold_ff <= mosi_q;
      end
   end

   always_comb begin
      rsp.host_status = st_ff;
      rsp.read_data = !rdsel_ff ? 8'h00 : (fresh_ff ? mem_q : rdata_ff);
      rsp.spi_active = act_ff;
      rsp.chip_select_n = act_ff ? cs_ff : 1'b1;
      rsp.mosi_byte = !act_ff ? 8'h00 : (fresh_ff ? mosi_q : mosi_hold_ff);
      rsp.sequence_idle = idle_ff;
   end

endmodule

[design/spi_flash_sector_writeback_cache.sv]
// top level of the single-sector write-back cache for a spi nor flash
// depends on sfwc_pkg, sfwc_controller, sfwc_datapath
//
// usage: the req channel carries one item per host byte access, flush or
// spi tick; the rsp channel returns exactly one item for each.
// a host read or write hitting the held 4096-byte sector is served at once;
// a miss answers status 2 and starts a write-back and/or load, and the
// host reissues the item once sequence_idle returns to 1. host items that
// arrive while a sequence runs answer status 1 and change nothing.
// each tick item in a sequence drives one spi byte: spi_active, chip_select_n
// and mosi_byte describe it, and the next tick carries the miso byte it got.
// latency: the result is valid the cycle after the item is accepted.
// the single result register must drain before the next item is taken,
// and a stalled rsp_ready holds req_ready low with the result unchanged.
// reset clears the phase, counters and valid/dirty flags; the sector
// store needs no clearing since the valid flag guards it.
`timescale 1ns / 1ps
module spi_flash_sector_writeback_cache (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sfwc_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output sfwc_pkg::rsp_type rsp_data
);

   sfwc_pkg::ctl_type ctl;
   sfwc_pkg::sts_type sts;
   logic valid_q;
   logic [sfwc_pkg::SEC_W-1:0] current_sector;
   logic [7:0] mem_q;
   logic [7:0] mosi_q;

   sfwc_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req_data),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp(rsp_data),
      .ctl(ctl), .sts(sts), .valid_q(valid_q), .current_sector(current_sector),
      .mem_q(mem_q), .mosi_q(mosi_q)
   );

   sfwc_datapath u_dp (
      .clock(clock), .req(req_data), .ctl(ctl), .valid_q(valid_q),
      .current_sector(current_sector), .sts(sts),
      .mem_q(mem_q), .mosi_q(mosi_q)
   );

endmodule
